// ===== design/fse_pkg.sv =====
`timescale 1ns / 1ps

package fse_pkg;

   localparam int MAX_ENTRIES  = 6;
   localparam int TIME_BITS    = 16;
   localparam int ALPHA_BITS   = 8;
   localparam int ELAPSED_BITS = 17;
   localparam int ENTRY_BITS   = 3;
   localparam int WORD_BITS    = 49;
   localparam int FIELD_BITS   = 16;
   localparam int VALID_BIT    = 48;
   localparam int NUM_BITS     = ELAPSED_BITS + ALPHA_BITS;
   localparam int CNT_BITS     = $clog2(ALPHA_BITS);

   localparam logic [ALPHA_BITS-1:0]   ALPHA_MAX   = {ALPHA_BITS{1'b1}};
   localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SKIP  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   localparam logic [1:0] PH_IN   = 2'd0;
   localparam logic [1:0] PH_HOLD = 2'd1;
   localparam logic [1:0] PH_OUT  = 2'd2;
   localparam logic [1:0] PH_IDLE = 2'd3;

   localparam logic [2:0] CSR_ENTRY_COUNT = 3'd6;
   localparam logic [2:0] CSR_ALLOW_SKIP  = 3'd7;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_DIV,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } status_type;

endpackage

// ===== design/fade_sequence_engine_top.sv =====
`timescale 1ns / 1ps
// fade-in / hold / fade-out envelope sequencer over up to six entries
// request channel: req_valid, req_stall, req_kind (tick, skip, start), req_delta
// result channel: rsp_valid, rsp_stall, alpha, entry index, phase, complete flags
// csr channel: csr_valid, csr_ready, csr_index, csr_wdata; ready is always high,
// write only while no transaction is in flight
// every request transaction yields exactly one result transaction
// an accepted request passes through evaluate, the ramp divide if a fade tick
// needs it (one quotient bit per cycle), and commit; rsp_valid is registered
// at commit; a new request is taken only after the previous one has committed
// the next request is taken while a result still waits on rsp_stall; that
// request then holds in its commit state until the pending result is taken
// reset: synchronous, clears entries, count and sequencer state, allow_skip = 1
// after completion, start, tick and skip leave the state unchanged until reset
module fade_sequence_engine_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic [15:0]                        req_delta,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fse_pkg::ALPHA_BITS-1:0]     rsp_alpha,
   output logic [fse_pkg::ENTRY_BITS-1:0]     rsp_entry_index,
   output logic [1:0]                         rsp_phase,
   output logic                               rsp_complete,
   output logic                               rsp_just_completed,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [fse_pkg::WORD_BITS-1:0]      csr_wdata
);

   fse_pkg::cmd_type    cmd;
   fse_pkg::status_type status;

   assign csr_ready = 1'b1;

   fse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fse_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_delta          (req_delta),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_alpha          (rsp_alpha),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_phase          (rsp_phase),
      .rsp_complete       (rsp_complete),
      .rsp_just_completed (rsp_just_completed)
   );

endmodule

// ===== design/fse_ctrl.sv =====
`timescale 1ns / 1ps

module fse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fse_pkg::status_type status,
   output fse_pkg::cmd_type    cmd
);

   fse_pkg::state_type              state_ff, state_in;
   logic [fse_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fse_pkg::S_IDLE: begin
            if (req_valid) state_in = fse_pkg::S_EVAL;
         end
         fse_pkg::S_EVAL: begin
            if (status.need_div) state_in = fse_pkg::S_DIV;
            else state_in = fse_pkg::S_COMMIT;
         end
         fse_pkg::S_DIV: begin
            if (cnt_ff == '0) state_in = fse_pkg::S_COMMIT;
         end
         fse_pkg::S_COMMIT: begin
            if (status.out_free) state_in = fse_pkg::S_IDLE;
         end
         default: state_in = fse_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      cnt_in    = cnt_ff;
      case (state_ff)
         fse_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         fse_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
            cnt_in   = fse_pkg::CNT_BITS'(fse_pkg::ALPHA_BITS - 1);
         end
         fse_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
         end
         fse_pkg::S_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fse_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/fse_datapath.sv =====
`timescale 1ns / 1ps

module fse_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  fse_pkg::cmd_type                   cmd,
   output fse_pkg::status_type                status,
   input  logic [1:0]                         req_kind,
   input  logic [15:0]                        req_delta,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [fse_pkg::WORD_BITS-1:0]      csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fse_pkg::ALPHA_BITS-1:0]     rsp_alpha,
   output logic [fse_pkg::ENTRY_BITS-1:0]     rsp_entry_index,
   output logic [1:0]                         rsp_phase,
   output logic                               rsp_complete,
   output logic                               rsp_just_completed
);

   localparam int ELB = fse_pkg::ELAPSED_BITS;
   localparam int TB  = fse_pkg::TIME_BITS;
   localparam int AB  = fse_pkg::ALPHA_BITS;
   localparam int NB  = fse_pkg::NUM_BITS;
   localparam int EB  = fse_pkg::ENTRY_BITS;

   // configuration
   logic [fse_pkg::WORD_BITS-1:0] entry_ff [fse_pkg::MAX_ENTRIES];
   logic [EB-1:0]                 count_ff;
   logic                          allow_skip_ff;

   // sequencer state
   logic [1:0]     phase_ff, phase_in;
   logic [EB-1:0]  cur_ff, cur_in;
   logic [ELB-1:0] elapsed_ff, elapsed_in;
   logic [AB-1:0]  alpha_ff, alpha_in;
   logic           running_ff, running_in;
   logic           done_ff, done_in;
   logic           pulse_ff, pulse_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // transaction and divider
   logic [1:0]     kind_ff;
   logic [15:0]    delta_ff;
   logic [ELB-1:0] t_ff;
   logic [TB-1:0]  d_ff;
   logic [NB-1:0]  rem_ff;
   logic [NB-1:0]  dsh_ff;
   logic [AB-1:0]  quo_ff;

   logic [EB-1:0]  used;
   logic [ELB:0]   sum;
   logic [ELB-1:0] t_now;
   logic [TB-1:0]  d_now;
   logic [NB-1:0]  num_now;
   logic           sat_now;
   logic           ramp_phase;
   logic           ge;
   logic [EB-1:0]  first_valid;
   logic [EB-1:0]  next_valid;
   logic           t_done;

   function automatic logic [EB-1:0] find_valid(
      input logic [EB-1:0]                 start,
      input logic [EB-1:0]                 limit,
      input logic [fse_pkg::MAX_ENTRIES-1:0] valid
   );
      logic [EB-1:0] r;
      r = limit;
      for (int i = fse_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
         if (EB'(i) >= start && EB'(i) < limit && valid[i]) r = EB'(i);
      end
      return r;
   endfunction

   logic [fse_pkg::MAX_ENTRIES-1:0] valid_bits;

   always_comb begin
      for (int i = 0; i < fse_pkg::MAX_ENTRIES; i++) begin
         valid_bits[i] = entry_ff[i][fse_pkg::VALID_BIT];
      end
   end

   assign used = (count_ff > EB'(fse_pkg::MAX_ENTRIES)) ? EB'(fse_pkg::MAX_ENTRIES) : count_ff;
   assign first_valid = find_valid('0, used, valid_bits);
   assign next_valid  = find_valid(cur_ff + 1'b1, used, valid_bits);

   // evaluation of the captured transaction
   assign sum   = {1'b0, elapsed_ff} + (ELB + 1)'(delta_ff);
   assign t_now = sum[ELB] ? fse_pkg::ELAPSED_MAX : sum[ELB-1:0];

   always_comb begin
      case (phase_ff)
         fse_pkg::PH_IN:   d_now = entry_ff[cur_ff][0 +: TB];
         fse_pkg::PH_HOLD: d_now = entry_ff[cur_ff][fse_pkg::FIELD_BITS +: TB];
         fse_pkg::PH_OUT:  d_now = entry_ff[cur_ff][2 * fse_pkg::FIELD_BITS +: TB];
         default:          d_now = '0;
      endcase
   end

   assign num_now    = NB'(t_now) * NB'(fse_pkg::ALPHA_MAX);
   assign sat_now    = num_now >= {NB'(d_now), AB'(0)} >> 0 ? 1'b1 : 1'b0;
   assign ramp_phase = (phase_ff == fse_pkg::PH_IN) || (phase_ff == fse_pkg::PH_OUT);

   assign status.need_div = (kind_ff == fse_pkg::KIND_TICK) && running_ff && !done_ff &&
                            ramp_phase && (d_now != '0) && !sat_now;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign ge = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         delta_ff <= req_delta;
      end
      if (cmd.eval) begin
         t_ff   <= t_now;
         d_ff   <= d_now;
         rem_ff <= num_now;
         dsh_ff <= NB'(d_now) << (AB - 1);
         quo_ff <= sat_now ? fse_pkg::ALPHA_MAX : '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? rem_ff - dsh_ff : rem_ff;
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[AB-2:0], ge};
      end
   end

   // commit of the step
   assign t_done = t_ff >= ELB'(d_ff);

   always_comb begin
      phase_in   = phase_ff;
      cur_in     = cur_ff;
      elapsed_in = elapsed_ff;
      alpha_in   = alpha_ff;
      running_in = running_ff;
      done_in    = done_ff;
      pulse_in   = 1'b0;
      case (kind_ff)
         fse_pkg::KIND_START: begin
            if (!done_ff) begin
               if (first_valid >= used) begin
                  done_in    = 1'b1;
                  running_in = 1'b0;
                  phase_in   = fse_pkg::PH_IDLE;
                  pulse_in   = 1'b1;
               end else begin
                  cur_in     = first_valid;
                  phase_in   = fse_pkg::PH_IN;
                  elapsed_in = '0;
                  alpha_in   = '0;
                  running_in = 1'b1;
               end
            end
         end
         fse_pkg::KIND_SKIP: begin
            if (!done_ff && allow_skip_ff) begin
               done_in    = 1'b1;
               running_in = 1'b0;
               phase_in   = fse_pkg::PH_IDLE;
               pulse_in   = 1'b1;
            end
         end
         fse_pkg::KIND_TICK: begin
            if (running_ff && !done_ff) begin
               elapsed_in = t_ff;
               case (phase_ff)
                  fse_pkg::PH_IN: begin
                     alpha_in = (d_ff != '0) ? quo_ff : fse_pkg::ALPHA_MAX;
                     if (t_done) begin
                        phase_in   = fse_pkg::PH_HOLD;
                        elapsed_in = '0;
                     end
                  end
                  fse_pkg::PH_HOLD: begin
                     alpha_in = fse_pkg::ALPHA_MAX;
                     if (t_done) begin
                        phase_in   = fse_pkg::PH_OUT;
                        elapsed_in = '0;
                     end
                  end
                  fse_pkg::PH_OUT: begin
                     if (t_done && next_valid >= used) begin
                        done_in    = 1'b1;
                        running_in = 1'b0;
                        phase_in   = fse_pkg::PH_IDLE;
                        pulse_in   = 1'b1;
                     end else begin
                        alpha_in = (d_ff != '0) ? fse_pkg::ALPHA_MAX - quo_ff : '0;
                        if (t_done) begin
                           cur_in     = next_valid;
                           phase_in   = fse_pkg::PH_IN;
                           elapsed_in = '0;
                        end
                     end
                  end
                  default: begin
                     elapsed_in = elapsed_ff;
                  end
               endcase
            end
         end
         default: begin
            pulse_in = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fse_pkg::MAX_ENTRIES; i++) begin
            entry_ff[i] <= '0;
         end
         count_ff      <= '0;
         allow_skip_ff <= 1'b1;
         phase_ff      <= fse_pkg::PH_IDLE;
         cur_ff        <= '0;
         elapsed_ff    <= '0;
         alpha_ff      <= '0;
         running_ff    <= 1'b0;
         done_ff       <= 1'b0;
         pulse_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index < 3'(fse_pkg::MAX_ENTRIES)) begin
               entry_ff[csr_index] <= csr_wdata;
            end else if (csr_index == fse_pkg::CSR_ENTRY_COUNT) begin
               count_ff <= csr_wdata[EB-1:0];
            end else if (csr_index == fse_pkg::CSR_ALLOW_SKIP) begin
               allow_skip_ff <= csr_wdata[0];
            end
         end
         if (cmd.commit) begin
            phase_ff   <= phase_in;
            cur_ff     <= cur_in;
            elapsed_ff <= elapsed_in;
            alpha_ff   <= alpha_in;
            running_ff <= running_in;
            done_ff    <= done_in;
            pulse_ff   <= pulse_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alpha          = alpha_ff;
   assign rsp_entry_index    = cur_ff;
   assign rsp_phase          = phase_ff;
   assign rsp_complete       = done_ff;
   assign rsp_just_completed = pulse_ff;

endmodule
